[rtl/tlbc_pkg.sv]
// shared types and constants for the two-way translation buffer
`timescale 1ns / 1ps
`default_nettype none
package tlbc_pkg;

  localparam int unsigned AddrW       = 32;
  localparam int unsigned OffW        = 12;
  localparam int unsigned TagW        = AddrW - OffW;
  localparam int unsigned PteW        = 32;
  localparam int unsigned PteCBit     = 7;
  localparam int unsigned SetsDefault = 64;

  typedef enum logic [1:0] {
    MODE_LOOKUP = 2'd0,
    MODE_FILL   = 2'd1,
    MODE_INVAL  = 2'd2
  } mode_e;

  typedef enum logic [1:0] {
    KIND_PROBE  = 2'd0,
    KIND_READ   = 2'd1,
    KIND_WRITE  = 2'd2,
    KIND_IFETCH = 2'd3
  } kind_e;

  typedef enum logic [1:0] {
    ST_HIT   = 2'd0,
    ST_MISS  = 2'd1,
    ST_CHG   = 2'd2,
    ST_MAINT = 2'd3
  } status_e;

  typedef struct packed {
    logic [TagW-1:0] tag;
    logic [PteW-1:0] pte;
  } tlb_entry_t;

endpackage
`default_nettype wire

[rtl/two_way_tlb_with_change_bit.sv]
// data and instruction translation buffers, two ways each, with change bit tracking
//
//   channel | direction | handshake                 | payload
//   --------+-----------+---------------------------+-------------------------------------
//   in      | to block  | in_valid_i / in_ready_o   | mode, access_kind, virtual_address,
//           |           |                           | pte_word
//   out     | from block| out_valid_o / out_ready_i | status, phys_addr
//
// one request per cycle sustained while results are taken; a request passes through the
// input register (tag quotient by reciprocal multiply), the set read from the
// entry memory (set index from the remainder), then compare and update into the result register
// reset clears all valid bits and recent-way bits at once; no clearing pass
// a stalled result holds the pipeline stage behind it; empty stages keep taking requests
`timescale 1ns / 1ps
`default_nettype none
module two_way_tlb_with_change_bit
  import tlbc_pkg::*;
#(
  parameter int unsigned SETS = SetsDefault
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  output logic             in_ready_o,
  input  logic [1:0]       mode_i,
  input  logic [1:0]       access_kind_i,
  input  logic [AddrW-1:0] virtual_address_i,
  input  logic [PteW-1:0]  pte_word_i,
  output logic             out_valid_o,
  input  logic             out_ready_i,
  output logic [1:0]       status_o,
  output logic [AddrW-1:0] phys_addr_o
);

  // set index and row addressing: one row per buffer and set, both ways side by side
  localparam int unsigned SetW     = $clog2(SETS);
  localparam int unsigned RowW     = SetW + 1;
  localparam int unsigned Rows     = 2 ** RowW;
  localparam int unsigned ModShift = TagW + SetW;
  // reciprocal for tag / SETS, exact for every 20-bit tag
  localparam longint unsigned RecipL =
    ((64'd1 << ModShift) + 64'(SETS) - 64'd1) / 64'(SETS);
  localparam logic [TagW:0] Recip = RecipL[TagW:0];

  typedef tlb_entry_t [1:0] tlb_row_t;

  // handshake chain
  logic s1_valid_q, s2_valid_q, out_valid_q;
  logic out_free, s2_go, s2_free, s1_go, s1_free, in_go;

  assign out_free   = !out_valid_q || out_ready_i;
  assign s2_go      = s2_valid_q && out_free;
  assign s2_free    = !s2_valid_q || out_free;
  assign s1_go      = s1_valid_q && s2_free;
  assign s1_free    = !s1_valid_q || s2_free;
  assign in_ready_o = s1_free;
  assign in_go      = in_valid_i && s1_free;

  // stage 1: request register plus quotient of tag by set count
  logic [1:0]       s1_mode_q, s1_kind_q;
  logic [AddrW-1:0] s1_va_q;
  logic [PteW-1:0]  s1_pte_q;
  logic [TagW-1:0]  s1_quot_q;
  logic [2*TagW:0]  quot_prod;

  assign quot_prod = {(TagW+1)'(0), virtual_address_i[AddrW-1:OffW]} * {TagW'(0), Recip};

  always_ff @(posedge clk_i) begin
    if (in_go) begin
      s1_mode_q <= mode_i;
      s1_kind_q <= access_kind_i;
      s1_va_q   <= virtual_address_i;
      s1_pte_q  <= pte_word_i;
      s1_quot_q <= TagW'(quot_prod >> ModShift);
    end
  end

  // remainder gives the set; address of the row to read
  logic [TagW-1:0] s1_set_prod, s1_set_full;
  logic [SetW-1:0] s1_set;
  logic [RowW-1:0] rd_addr;

  assign s1_set_prod = s1_quot_q * TagW'(SETS);
  assign s1_set_full = s1_va_q[AddrW-1:OffW] - s1_set_prod;
  assign s1_set      = s1_set_full[SetW-1:0];
  assign rd_addr     = {kind_e'(s1_kind_q) == KIND_IFETCH, s1_set};

  // stage 2: request with set index and the row read from memory
  logic [1:0]       s2_mode_q, s2_kind_q;
  logic [AddrW-1:0] s2_va_q;
  logic [PteW-1:0]  s2_pte_q;
  logic [SetW-1:0]  s2_set_q;
  tlb_row_t         mem_rdata_q, byp_data_q;
  logic             byp_q;

  // entry memory, tag and page-table word of both ways per row
  tlb_row_t         mem_q [Rows];
  logic             mem_we;
  logic [RowW-1:0]  wr_addr;
  tlb_row_t         wr_data;

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem_q[wr_addr] <= wr_data;
    end
    if (s1_go) begin
      mem_rdata_q <= mem_q[rd_addr];
    end
  end

  // a row written in the same cycle it is read comes from the write data
  always_ff @(posedge clk_i) begin
    if (s1_go) begin
      s2_mode_q  <= s1_mode_q;
      s2_kind_q  <= s1_kind_q;
      s2_va_q    <= s1_va_q;
      s2_pte_q   <= s1_pte_q;
      s2_set_q   <= s1_set;
      byp_data_q <= wr_data;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      byp_q <= 1'b0;
    end else if (s1_go) begin
      byp_q <= mem_we && (wr_addr == rd_addr);
    end
  end

  // valid and recent-way bits live in flops so reset clears them
  logic [1:0] valid_q [Rows];
  logic       recent_q [Rows];

  // stage 2 compare and update
  logic            s2_buf;
  logic [RowW-1:0] s2_row;
  logic [TagW-1:0] s2_tag;
  tlb_row_t        cur_row;
  logic [1:0]      cur_vld;
  logic            hit0, hit1, hit_any, hit_way, fill_way;
  logic            chg_set, hit_upd, fill_en, inval_en;
  logic [1:0]      res_status;
  logic [AddrW-1:0] res_phys;

  assign s2_buf  = kind_e'(s2_kind_q) == KIND_IFETCH;
  assign s2_row  = {s2_buf, s2_set_q};
  assign s2_tag  = s2_va_q[AddrW-1:OffW];
  assign cur_row = byp_q ? byp_data_q : mem_rdata_q;
  assign cur_vld = valid_q[s2_row];

  // way 0 wins when both ways hold the tag
  assign hit0     = cur_vld[0] && (cur_row[0].tag == s2_tag);
  assign hit1     = cur_vld[1] && (cur_row[1].tag == s2_tag);
  assign hit_any  = hit0 || hit1;
  assign hit_way  = !hit0;
  // fill goes to way 1 only when way 0 is valid and was the recent one
  assign fill_way = !recent_q[s2_row] && cur_vld[0];

  always_comb begin
    logic lookup;
    logic c_clear;
    lookup     = mode_e'(s2_mode_q) == MODE_LOOKUP;
    c_clear    = !cur_row[hit_way].pte[PteCBit];
    chg_set    = lookup && hit_any && kind_e'(s2_kind_q) == KIND_WRITE && c_clear;
    hit_upd    = lookup && hit_any && !chg_set && kind_e'(s2_kind_q) != KIND_PROBE;
    fill_en    = mode_e'(s2_mode_q) == MODE_FILL && kind_e'(s2_kind_q) != KIND_PROBE;
    inval_en   = mode_e'(s2_mode_q) == MODE_INVAL;
    res_status = ST_MAINT;
    res_phys   = '0;
    if (lookup) begin
      if (!hit_any) begin
        res_status = ST_MISS;
      end else if (chg_set) begin
        res_status = ST_CHG;
      end else begin
        res_status = ST_HIT;
        res_phys   = {cur_row[hit_way].pte[PteW-1:OffW], s2_va_q[OffW-1:0]};
      end
    end
    // row write: either a new entry or the change bit set in the hit way
    wr_data = cur_row;
    if (fill_en) begin
      wr_data[fill_way].tag = s2_tag;
      wr_data[fill_way].pte = s2_pte_q;
    end else begin
      wr_data[hit_way].pte[PteCBit] = 1'b1;
    end
  end

  assign mem_we  = s2_go && (fill_en || chg_set);
  assign wr_addr = s2_row;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int r = 0; r < Rows; r++) begin
        valid_q[r]  <= 2'b00;
        recent_q[r] <= 1'b0;
      end
    end else if (s2_go) begin
      if (fill_en) begin
        valid_q[s2_row][fill_way] <= 1'b1;
        recent_q[s2_row]          <= fill_way;
      end else if (hit_upd) begin
        recent_q[s2_row] <= hit_way;
      end else if (inval_en) begin
        // same set in both buffers
        valid_q[{1'b0, s2_set_q}] <= 2'b00;
        valid_q[{1'b1, s2_set_q}] <= 2'b00;
      end
    end
  end

  // result register
  logic [1:0]       status_q;
  logic [AddrW-1:0] phys_q;

  always_ff @(posedge clk_i) begin
    if (s2_go) begin
      status_q <= res_status;
      phys_q   <= res_phys;
    end
  end

  // pipeline occupancy
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      s2_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (s1_free) begin
        s1_valid_q <= in_valid_i;
      end
      if (s2_free) begin
        s2_valid_q <= s1_valid_q;
      end
      if (out_free) begin
        out_valid_q <= s2_valid_q;
      end
    end
  end

  assign out_valid_o = out_valid_q;
  assign status_o    = status_q;
  assign phys_addr_o = phys_q;

endmodule
`default_nettype wire

[rtl/tlbc_checker.sv]
// port-level checks for the translation buffer, bound to the top level
`timescale 1ns / 1ps
`default_nettype none
module tlbc_checker
  import tlbc_pkg::*;
(
  input wire logic             clk_i,
  input wire logic             rst_ni,
  input wire logic             in_valid_i,
  input wire logic             in_ready_o,
  input wire logic             out_valid_o,
  input wire logic             out_ready_i,
  input wire logic [1:0]       status_o,
  input wire logic [AddrW-1:0] phys_addr_o
);

  // requests taken and not yet delivered
  logic [2:0] pending_q;
  logic       in_fire, out_fire;

  assign in_fire  = in_valid_i && in_ready_o;
  assign out_fire = out_valid_o && out_ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pending_q <= 3'd0;
    end else if (in_fire && !out_fire) begin
      pending_q <= pending_q + 3'd1;
    end else if (out_fire && !in_fire) begin
      pending_q <= pending_q - 3'd1;
    end
  end

  a_phys_zero_unless_hit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && status_o != ST_HIT |-> phys_addr_o == '0)
    else $error("nonzero address on a result that is not a hit");

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(status_o) && $stable(phys_addr_o))
    else $error("stalled result changed");

  a_no_spurious_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> pending_q != 3'd0)
    else $error("result without an outstanding request");

  a_depth_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pending_q == 3'd3 |-> !in_ready_o || out_ready_i)
    else $error("more requests in flight than pipeline stages");

endmodule

bind two_way_tlb_with_change_bit tlbc_checker u_tlbc_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_valid_i),
  .in_ready_o  (in_ready_o),
  .out_valid_o (out_valid_o),
  .out_ready_i (out_ready_i),
  .status_o    (status_o),
  .phys_addr_o (phys_addr_o)
);
`default_nettype wire
